/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL files that check themselves.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same check, also active during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/core/macp_pkg.sv */
// Shared types and constants of the MAC address text parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package macp_pkg;

    localparam logic [7:0] C_CHAR_COLON = 8'h3A;
    localparam logic [7:0] C_CHAR_DASH  = 8'h2D;
    localparam logic [3:0] C_PLAIN_DIGITS = 4'd12;
    localparam logic [2:0] C_MAC_BYTES    = 3'd6;
    localparam int         C_MAC_W        = 48;

    // One character after classification.
    typedef struct packed {
        logic [3:0] digit;
        logic       is_hex;
        logic       is_sep;
        logic       last;
    } t_char_cls;

    // Queue status seen by the back end and the checks.
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

endpackage

`default_nettype wire

/* rtl/core/mac_address_text_parser_unit.sv */
// Top level of the MAC address text parser: front decoder, queue, back end.
// Depends on macp_pkg, macp_front, macp_queue, macp_back, assert_macros.svh.
//
//  channel | handshake        | payload
//  --------+------------------+------------------------------------
//  input   | push / full      | i_char_code[7:0], i_last_char
//  result  | empty / pop      | o_valid_res, o_mac_address[47:0]
//
// One character per cycle sustained while no waiting result stalls the queue; a result
// reaches the ports through the queue write and then the back-end update.
// The back-end state register update is the loop that sets the rate.
// Reset is synchronous and empties the queue and the result slot; the result value and valid bit are not reset.
// A waiting result stalls the queue only once a final character reaches its head;
// full then rises after one more character.
`default_nettype none

`include "assert_macros.svh"

module mac_address_text_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_last_char,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_valid_res,
    output logic [47:0]      o_mac_address
);
    import macp_pkg::*;

    t_char_cls w_front_cls;
    t_char_cls w_q_cls;
    t_q_stat   w_q_stat;
    logic      w_take;
    logic      w_res_avail;

    macp_front u_front (
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_cls       (w_front_cls)
    );

    macp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push && !w_q_stat.full),
        .i_data  (w_front_cls),
        .i_rd    (w_take),
        .o_data  (w_q_cls),
        .o_stat  (w_q_stat)
    );

    macp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cls         (w_q_cls),
        .i_q_stat      (w_q_stat),
        .o_take        (w_take),
        .i_res_pop     (pop),
        .o_res_avail   (w_res_avail),
        .o_valid_res   (o_valid_res),
        .o_mac_address (o_mac_address)
    );

    assign full  = w_q_stat.full;
    assign empty = !w_res_avail;

    // an invalid parse must never carry address bits
    `ASSERT_CLK(a_mac_zero_if_invalid, !empty && !o_valid_res |-> o_mac_address == 48'd0, "invalid result with nonzero address")
    // a queued character is not dropped unless the back end takes it
    `ASSERT_CLK(a_queue_keeps_item, w_q_stat.valid && !w_take |=> w_q_stat.valid, "queued character lost")
    // an unpopped result stays put, whatever the queue holds
    `ASSERT_CLK(a_result_held, !empty && !pop |=> !empty && $stable(o_mac_address), "pending result overwritten")

endmodule

`default_nettype wire

/* rtl/core/macp_front.sv */
// Front end: decodes one incoming character into hex value and class flags.
// Depends on macp_pkg.
`default_nettype none

module macp_front (
    input  wire logic [7:0]          i_char_code,
    input  wire logic                i_last_char,
    output macp_pkg::t_char_cls      o_cls
);
    import macp_pkg::*;

    logic [7:0] w_lc;
    logic       w_dec;
    logic       w_alpha;

    always_comb begin
        w_lc    = i_char_code | 8'h20;   // fold case for letters
        w_dec   = (i_char_code >= 8'h30) && (i_char_code <= 8'h39);
        w_alpha = (w_lc >= 8'h61) && (w_lc <= 8'h66);
        o_cls.is_hex = w_dec || w_alpha;
        o_cls.is_sep = (i_char_code == C_CHAR_COLON) || (i_char_code == C_CHAR_DASH);
        o_cls.last   = i_last_char;
        if (w_dec) begin
            o_cls.digit = i_char_code[3:0];
        end else if (w_alpha) begin
            o_cls.digit = w_lc[3:0] + 4'd9;
        end else begin
            o_cls.digit = 4'd0;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/macp_queue.sv */
// Two-entry queue of classified characters between front and back end.
// Depends on macp_pkg.
`default_nettype none

module macp_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr,
    input  macp_pkg::t_char_cls      i_data,
    input  wire logic                i_rd,
    output macp_pkg::t_char_cls      o_data,
    output macp_pkg::t_q_stat        o_stat
);
    import macp_pkg::*;

    t_char_cls  r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_wr;
        n_rd_ptr = r_rd_ptr ^ i_rd;
        n_count  = r_count + {1'b0, i_wr} - {1'b0, i_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.valid = (r_count != 2'd0);

endmodule

`default_nettype wire

/* rtl/core/macp_back.sv */
// Back end: runs the separator and plain readings side by side and holds
// the result register. Depends on macp_pkg.
`default_nettype none

module macp_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  macp_pkg::t_char_cls      i_cls,
    input  macp_pkg::t_q_stat        i_q_stat,
    output logic                     o_take,
    input  wire logic                i_res_pop,
    output logic                     o_res_avail,
    output logic                     o_valid_res,
    output logic [47:0]              o_mac_address
);
    import macp_pkg::*;

    logic [7:0]  r_group_value, n_group_value;
    logic [1:0]  r_group_digits, n_group_digits;
    logic [2:0]  r_group_count, n_group_count;
    logic        r_sep_err, n_sep_err;
    logic [47:0] r_sep_bytes, n_sep_bytes;
    logic [3:0]  r_plain_cnt, n_plain_cnt;
    logic        r_plain_err, n_plain_err;
    logic [47:0] r_plain_bytes, n_plain_bytes;
    logic        r_sep_seen, n_sep_seen;

    logic        r_out_full, n_out_full;
    logic        r_valid_res, n_valid_res;
    logic [47:0] r_mac, n_mac;

    logic        w_res_taken;
    logic [2:0]  w_fin_count;
    logic [47:0] w_fin_bytes;
    logic        w_ok;

    assign w_res_taken = i_res_pop && r_out_full;
    // a final character needs a free result slot; others go straight in
    assign o_take = i_q_stat.valid && (!i_cls.last || !r_out_full || i_res_pop);

    always_comb begin
        n_group_value  = r_group_value;
        n_group_digits = r_group_digits;
        n_group_count  = r_group_count;
        n_sep_err      = r_sep_err;
        n_sep_bytes    = r_sep_bytes;
        n_plain_cnt    = r_plain_cnt;
        n_plain_err    = r_plain_err;
        n_plain_bytes  = r_plain_bytes;
        n_sep_seen     = r_sep_seen;
        n_out_full     = r_out_full && !w_res_taken;
        n_valid_res    = r_valid_res;
        n_mac          = r_mac;
        w_fin_count    = '0;
        w_fin_bytes    = '0;
        w_ok           = 1'b0;

        if (o_take) begin
            // separator reading
            if (i_cls.is_sep) begin
                n_sep_seen = 1'b1;
                if (r_group_count >= C_MAC_BYTES || r_group_digits == 2'd0) begin
                    n_sep_err = 1'b1;
                end else begin
                    n_sep_bytes    = {r_sep_bytes[39:0], r_group_value};
                    n_group_count  = r_group_count + 3'd1;
                    n_group_value  = 8'd0;
                    n_group_digits = 2'd0;
                end
            end else if (i_cls.is_hex) begin
                if (r_group_count >= C_MAC_BYTES || r_group_digits >= 2'd2) begin
                    n_sep_err = 1'b1;
                end else begin
                    n_group_value  = {r_group_value[3:0], i_cls.digit};
                    n_group_digits = r_group_digits + 2'd1;
                end
            end else begin
                n_sep_err = 1'b1;
            end

            // plain reading; count saturates one past twelve
            if (i_cls.is_hex && r_plain_cnt < C_PLAIN_DIGITS) begin
                n_plain_bytes = {r_plain_bytes[43:0], i_cls.digit};
            end else begin
                n_plain_err = 1'b1;
            end
            if (r_plain_cnt <= C_PLAIN_DIGITS) begin
                n_plain_cnt = r_plain_cnt + 4'd1;
            end

            if (i_cls.last) begin
                // close an unterminated final group
                if (n_group_digits != 2'd0 && n_group_count < C_MAC_BYTES) begin
                    w_fin_bytes = {n_sep_bytes[39:0], n_group_value};
                    w_fin_count = n_group_count + 3'd1;
                end else begin
                    w_fin_bytes = n_sep_bytes;
                    w_fin_count = n_group_count;
                end
                if (n_sep_seen) begin
                    w_ok  = !n_sep_err && (w_fin_count == C_MAC_BYTES);
                    n_mac = w_ok ? w_fin_bytes : '0;
                end else begin
                    w_ok  = !n_plain_err && (n_plain_cnt == C_PLAIN_DIGITS);
                    n_mac = w_ok ? n_plain_bytes : '0;
                end
                n_valid_res    = w_ok;
                n_out_full     = 1'b1;
                n_group_value  = '0;
                n_group_digits = '0;
                n_group_count  = '0;
                n_sep_err      = 1'b0;
                n_sep_bytes    = '0;
                n_plain_cnt    = '0;
                n_plain_err    = 1'b0;
                n_plain_bytes  = '0;
                n_sep_seen     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_value  <= '0;
            r_group_digits <= '0;
            r_group_count  <= '0;
            r_sep_err      <= 1'b0;
            r_sep_bytes    <= '0;
            r_plain_cnt    <= '0;
            r_plain_err    <= 1'b0;
            r_plain_bytes  <= '0;
            r_sep_seen     <= 1'b0;
            r_out_full     <= 1'b0;
        end else begin
            r_group_value  <= n_group_value;
            r_group_digits <= n_group_digits;
            r_group_count  <= n_group_count;
            r_sep_err      <= n_sep_err;
            r_sep_bytes    <= n_sep_bytes;
            r_plain_cnt    <= n_plain_cnt;
            r_plain_err    <= n_plain_err;
            r_plain_bytes  <= n_plain_bytes;
            r_sep_seen     <= n_sep_seen;
            r_out_full     <= n_out_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_valid_res <= n_valid_res;
        r_mac       <= n_mac;
    end

    assign o_res_avail   = r_out_full;
    assign o_valid_res   = r_valid_res;
    assign o_mac_address = r_mac;

endmodule

`default_nettype wire
